### design/hcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcl_pkg;

   localparam logic [7:0] SYNC_BYTE    = 8'h80;
   localparam logic [7:0] CHAR_OPEN    = 8'h42;
   localparam logic [7:0] CHAR_CONTROL = 8'h63;
   localparam logic [7:0] CHAR_WRITE   = 8'h77;
   localparam logic [7:0] CHAR_READ    = 8'h72;
   localparam logic [7:0] CHAR_SAVE    = 8'h73;
   localparam logic [7:0] CHAR_ERASE   = 8'h65;
   localparam logic [7:0] CHAR_RESET   = 8'h52;
   localparam logic [7:0] CHAR_CLOSE   = 8'h45;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int FRAME_BYTES = 8;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   typedef enum logic [2:0] {
      CMD_OPEN,
      CMD_CONTROL,
      CMD_WRITE,
      CMD_READ,
      CMD_SAVE,
      CMD_ERASE,
      CMD_RESET,
      CMD_CLOSE
   } cmd_code_type;

   typedef enum logic [1:0] {
      EXEC_IDLE,
      EXEC_READ,
      EXEC_SEND
   } exec_state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [7:0] target_address;
      logic [7:0] target_output;
      logic       in_reg_zero;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_last;
      logic       clock_enable;
      logic       reset_enable;
      logic       switch_source;
      logic       address_drive;
      logic       in_bus_drive;
      logic [7:0] address_out;
      logic [7:0] in_value_out;
      logic       reset_request;
   } rsp_word_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic [7:0]   addr;
      logic [7:0]   hi;
      logic [7:0]   lo;
      logic [7:0]   target_address;
      logic [7:0]   target_output;
      logic         in_reg_zero;
   } cmd_entry_type;

endpackage

`default_nettype wire

### design/hcl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/hcl_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module hcl_rx
   import hcl_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_push,
   input  req_word_type  req_word,
   input  wire           q_full,
   output logic          q_push,
   output cmd_entry_type q_entry,
   output logic          req_full
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       cmd_ff, addr_ff, hi_ff, lo_ff;
   logic             accept;
   logic             known;
   cmd_code_type     code;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      known = 1'b1;
      code  = CMD_SAVE;
      unique case (cmd_ff)
         CHAR_OPEN:    code = CMD_OPEN;
         CHAR_CONTROL: code = CMD_CONTROL;
         CHAR_WRITE:   code = CMD_WRITE;
         CHAR_READ:    code = CMD_READ;
         CHAR_SAVE:    code = CMD_SAVE;
         CHAR_ERASE:   code = CMD_ERASE;
         CHAR_RESET:   code = CMD_RESET;
         CHAR_CLOSE:   code = CMD_CLOSE;
         default:      known = 1'b0;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      q_push = 1'b0;
      if (accept) begin
         if (pos_ff == '0) begin
            if (req_word.rx_byte == SYNC_BYTE) begin
               sum_in = req_word.rx_byte;
               pos_in = POS_W'(1);
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in = '0;
            q_push = (sum_ff == req_word.rx_byte) && known;
         end else begin
            sum_in = sum_ff + req_word.rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (pos_ff)
            POS_W'(1): cmd_ff  <= req_word.rx_byte;
            POS_W'(2): addr_ff <= req_word.rx_byte;
            POS_W'(3): hi_ff   <= req_word.rx_byte;
            POS_W'(4): lo_ff   <= req_word.rx_byte;
            default: begin
            end
         endcase
      end
   end

   assign q_entry.cmd            = code;
   assign q_entry.addr           = addr_ff;
   assign q_entry.hi             = hi_ff;
   assign q_entry.lo             = lo_ff;
   assign q_entry.target_address = req_word.target_address;
   assign q_entry.target_output  = req_word.target_output;
   assign q_entry.in_reg_zero    = req_word.in_reg_zero;

endmodule

`default_nettype wire

### design/hcl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hcl_queue
   import hcl_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           push,
   input  cmd_entry_type push_entry,
   output logic          full,
   input  wire           pop,
   output logic          empty,
   output cmd_entry_type head
);

   cmd_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // depth is a power of two, pointers wrap on their own
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W + 1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QUEUE_PTR_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### design/hcl_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module hcl_exec
   import hcl_pkg::*;
#(
   parameter int PROGRAM_WORDS = 256
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           q_empty,
   input  cmd_entry_type q_head,
   output logic          q_pop,
   output logic          rsp_empty,
   input  wire           rsp_pop,
   output rsp_word_type  rsp_word
);

   localparam int AW = $clog2(PROGRAM_WORDS);

   exec_state_type         state_ff, state_in;
   logic                   link_ff, link_in;
   logic [7:0]             mode_ff, mode_in;
   logic [4:0]             pins_ff, pins_in;
   logic [7:0]             addr_out_ff, addr_out_in;
   logic [7:0]             in_val_ff, in_val_in;
   logic [7:0]             d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in;
   logic                   rst_req_ff, rst_req_in;
   logic [POS_W-1:0]       idx_ff, idx_in;
   logic [7:0]             sum_ff, sum_in;
   logic [PROGRAM_WORDS-1:0] valid_ff, valid_in;
   logic                   hit_ff, hit_in;
   logic                   in_range;
   logic                   ram_wr;
   logic [15:0]            ram_rd_data;
   logic [7:0]             tx;

   assign in_range = ({1'b0, q_head.addr} < 9'(PROGRAM_WORDS));

   hcl_ram #(
      .WIDTH (16),
      .DEPTH (PROGRAM_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (q_head.addr[AW-1:0]),
      .wr_data ({q_head.hi, q_head.lo}),
      .rd_addr (q_head.addr[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      unique case (idx_ff)
         POS_W'(0), POS_W'(1): tx = SYNC_BYTE;
         POS_W'(2):            tx = d0_ff;
         POS_W'(3):            tx = d1_ff;
         POS_W'(4):            tx = d2_ff;
         POS_W'(5), POS_W'(6): tx = 8'h00;
         default:              tx = sum_ff;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      link_in     = link_ff;
      mode_in     = mode_ff;
      pins_in     = pins_ff;
      addr_out_in = addr_out_ff;
      in_val_in   = in_val_ff;
      d0_in       = d0_ff;
      d1_in       = d1_ff;
      d2_in       = d2_ff;
      rst_req_in  = rst_req_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      q_pop       = 1'b0;
      ram_wr      = 1'b0;
      unique case (state_ff)
         EXEC_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty && (q_head.cmd == CMD_OPEN || link_ff)) begin
               state_in   = EXEC_SEND;
               idx_in     = '0;
               sum_in     = '0;
               d0_in      = '0;
               d1_in      = '0;
               d2_in      = '0;
               rst_req_in = 1'b0;
               unique case (q_head.cmd)
                  CMD_OPEN: link_in = 1'b1;
                  CMD_CONTROL: begin
                     if (mode_ff != q_head.lo) begin
                        mode_in      = q_head.lo;
                        pins_in[3:0] = q_head.lo[3:0];
                        pins_in[4]   = q_head.lo[4] && (q_head.in_reg_zero || pins_ff[4]);
                     end
                     addr_out_in = q_head.addr;
                     in_val_in   = q_head.hi;
                     d0_in       = q_head.target_address;
                     d1_in       = q_head.target_output;
                     d2_in       = q_head.lo;
                  end
                  CMD_WRITE: begin
                     ram_wr = in_range;
                     if (in_range) begin
                        valid_in[q_head.addr[AW-1:0]] = 1'b1;
                     end
                     d0_in = q_head.addr;
                     d1_in = q_head.hi;
                     d2_in = q_head.lo;
                  end
                  CMD_READ: begin
                     state_in = EXEC_READ;
                     hit_in   = in_range && valid_ff[q_head.addr[AW-1:0]];
                     d0_in    = q_head.addr;
                  end
                  CMD_SAVE: begin
                  end
                  CMD_ERASE: valid_in = '0;
                  CMD_RESET: rst_req_in = 1'b1;
                  CMD_CLOSE: link_in = 1'b0;
                  default: begin
                  end
               endcase
            end
         end
         EXEC_READ: begin
            d1_in    = hit_ff ? ram_rd_data[15:8] : 8'h00;
            d2_in    = hit_ff ? ram_rd_data[7:0] : 8'h00;
            state_in = EXEC_SEND;
         end
         EXEC_SEND: begin
            if (rsp_pop) begin
               sum_in = sum_ff + tx;
               idx_in = idx_ff + POS_W'(1);
               if (idx_ff == POS_LAST) begin
                  state_in = EXEC_IDLE;
               end
            end
         end
         default: state_in = EXEC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= EXEC_IDLE;
         link_ff     <= 1'b0;
         mode_ff     <= '0;
         pins_ff     <= '0;
         addr_out_ff <= '0;
         in_val_ff   <= '0;
         valid_ff    <= '0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         link_ff     <= link_in;
         mode_ff     <= mode_in;
         pins_ff     <= pins_in;
         addr_out_ff <= addr_out_in;
         in_val_ff   <= in_val_in;
         valid_ff    <= valid_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff      <= d0_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      rst_req_ff <= rst_req_in;
      sum_ff     <= sum_in;
      hit_ff     <= hit_in;
   end

   assign rsp_empty              = (state_ff != EXEC_SEND);
   assign rsp_word.tx_byte       = tx;
   assign rsp_word.frame_last    = (idx_ff == POS_LAST);
   assign rsp_word.clock_enable  = pins_ff[0];
   assign rsp_word.reset_enable  = pins_ff[1];
   assign rsp_word.switch_source = pins_ff[2];
   assign rsp_word.address_drive = pins_ff[3];
   assign rsp_word.in_bus_drive  = pins_ff[4];
   assign rsp_word.address_out   = addr_out_ff;
   assign rsp_word.in_value_out  = in_val_ff;
   assign rsp_word.reset_request = rst_req_ff;

endmodule

`default_nettype wire

### design/host_command_link.sv
`timescale 1ns / 1ps
`default_nettype none

// host command link: framed command receiver and reply generator for a target cpu
// request side: one received byte per word with target readback levels, taken when
//   req_push is high and req_full is low; a byte can be taken every cycle
// reply side: one reply byte per word with the pin and bus levels, shown while
//   rsp_empty is low and taken when rsp_pop is high
// a valid eighth frame byte queues the command at once; the idle executor pops it from
//   the queue head and moves to the send state, through a read state first for a read,
//   since the program store has a registered read port
// a reply is eight words, one per cycle while rsp_pop stays high, and the executor
//   takes no new command until its last word is taken; the two-entry command
//   queue lets the receiver keep taking bytes while a reply is stalled, and
//   req_full rises only when the queue is full
// erase clears all the per-word valid bits together
// synchronous reset closes the link, clears pins, buses and the valid bits of the program
//   store and empties the queue; the receiver then waits for a sync byte

module host_command_link
   import hcl_pkg::*;
#(
   parameter int PROGRAM_WORDS = 256
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_push,
   output logic         req_full,
   input  req_word_type req_word,
   output logic         rsp_empty,
   input  wire          rsp_pop,
   output rsp_word_type rsp_word
);

   logic          q_push, q_full, q_pop, q_empty;
   cmd_entry_type q_in, q_head;

   hcl_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_in),
      .req_full (req_full)
   );

   hcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   hcl_exec #(
      .PROGRAM_WORDS (PROGRAM_WORDS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   a_last_ends_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && rsp_word.frame_last |=> rsp_empty)
      else $error("reply continued past its last word");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("block not idle after reset");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

endmodule

`default_nettype wire

### tb/sv/host_command_link_test.sv
`timescale 1ns / 1ps

module host_command_link_test;
   import hcl_pkg::*;

   localparam int STORE_WORDS = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_FRAME_BYTES = 96;
   localparam int DIRECTED_ROWS = 24;
   localparam logic [7:0] CHAR_UNKNOWN = 8'h78;

   typedef enum logic [1:0] {
      REPLY_PREDICTED,
      REPLY_ABSENT,
      REPLY_TYPED
   } reply_check_type;

   typedef struct packed {
      logic [7:0]      cmd;
      logic [7:0]      addr;
      logic [7:0]      hi;
      logic [7:0]      lo;
      logic [7:0]      taddr;
      logic [7:0]      tout;
      logic            izero;
      logic            bad_sum;
      reply_check_type check;
      logic [39:0]     data;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_word_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_word_type rsp_word;

   host_command_link #(
      .PROGRAM_WORDS(STORE_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_word(req_word),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_word(rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // link state as the host sees it
   int          link_pos;
   logic [7:0]  link_sum;
   logic [7:0]  link_frame [8];
   logic        link_is_open;
   logic [7:0]  link_mode;
   logic [4:0]  link_pins;
   logic [7:0]  link_addr_out;
   logic [7:0]  link_in_value;
   logic [15:0] link_store [STORE_WORDS];

   rsp_word_type  reply_words_due [$];
   rsp_word_type  reply_want;
   frame_row_type directed_rows [DIRECTED_ROWS];

   int error_count = 0;
   int cycle_count = 0;
   int frame_bytes_sent = 0;
   int steady_left = 0;
   int pop_run = 0;
   int pop_pick;
   logic pop_level = 1'b0;

   task automatic report_mismatch(input string field, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      if (error_count <= 100) begin
         $display("mismatch on %s: got %h want %h, cycle %0d", field, got, want,
                  cycle_count);
      end
   endtask

   task automatic queue_reply(input logic [39:0] data, input logic rst);
      rsp_word_type word;
      logic [7:0] sum;
      sum = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < 2) begin
            word.tx_byte = SYNC_BYTE;
         end else if (k < 7) begin
            word.tx_byte = data[39 - 8 * (k - 2) -: 8];
         end else begin
            word.tx_byte = sum;
         end
         sum = sum + word.tx_byte;
         word.frame_last = (k == 7);
         word.clock_enable = link_pins[0];
         word.reset_enable = link_pins[1];
         word.switch_source = link_pins[2];
         word.address_drive = link_pins[3];
         word.in_bus_drive = link_pins[4];
         word.address_out = link_addr_out;
         word.in_value_out = link_in_value;
         word.reset_request = rst;
         reply_words_due.push_back(word);
      end
   endtask

   task automatic decode_rx_byte(input req_word_type w, output logic reply,
                                 output logic [39:0] data, output logic rst);
      logic [7:0] b, cmd, a, hi, lo;
      b = w.rx_byte;
      reply = 1'b0;
      data = '0;
      rst = 1'b0;
      if (link_pos == 0) begin
         if (b == SYNC_BYTE) begin
            link_sum = b;
            link_frame[0] = b;
            link_pos = 1;
         end
         return;
      end
      if (link_pos < 7) begin
         link_frame[link_pos] = b;
         link_sum = link_sum + b;
         link_pos++;
         return;
      end
      link_pos = 0;
      if (link_sum != b) return;
      cmd = link_frame[1];
      a = link_frame[2];
      hi = link_frame[3];
      lo = link_frame[4];
      if (cmd == CHAR_OPEN) begin
         link_is_open = 1'b1;
         reply = 1'b1;
         return;
      end
      if (!link_is_open) return;
      reply = 1'b1;
      case (cmd)
         CHAR_CONTROL: begin
            if (link_mode != lo) begin
               link_mode = lo;
               link_pins[3:0] = lo[3:0];
               if (!lo[4]) begin
                  link_pins[4] = 1'b0;
               end else if (w.in_reg_zero) begin
                  link_pins[4] = 1'b1;
               end
            end
            link_addr_out = a;
            link_in_value = hi;
            data = {w.target_address, w.target_output, lo, 16'h0000};
         end
         CHAR_WRITE: begin
            if (a < STORE_WORDS) link_store[a] = {hi, lo};
            data = {a, hi, lo, 16'h0000};
         end
         CHAR_READ: begin
            data = {a, (a < STORE_WORDS) ? link_store[a] : 16'h0000, 16'h0000};
         end
         CHAR_SAVE: ;
         CHAR_ERASE: begin
            foreach (link_store[i]) link_store[i] = '0;
         end
         CHAR_RESET: rst = 1'b1;
         CHAR_CLOSE: link_is_open = 1'b0;
         default: reply = 1'b0;
      endcase
   endtask

   function automatic int pick_sender_gap();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         steady_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 40);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input req_word_type w, input reply_check_type check,
                            input logic [39:0] typed_data);
      logic reply, rst;
      logic [39:0] data;
      int gap;
      gap = pick_sender_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word <= w;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_rx_byte(w, reply, data, rst);
      if (check == REPLY_ABSENT) begin
         reply = 1'b0;
      end else if (check == REPLY_TYPED) begin
         reply = 1'b1;
         data = typed_data;
      end
      if (reply) queue_reply(data, rst);
      @(negedge clock);
   endtask

   task automatic send_frame(input frame_row_type row);
      req_word_type w;
      logic [7:0] frame [8];
      logic [7:0] sum;
      frame[0] = SYNC_BYTE;
      frame[1] = row.cmd;
      frame[2] = row.addr;
      frame[3] = row.hi;
      frame[4] = row.lo;
      frame[5] = 8'($urandom_range(0, 255));
      frame[6] = 8'($urandom_range(0, 255));
      sum = '0;
      for (int k = 0; k < 7; k++) sum = sum + frame[k];
      frame[7] = row.bad_sum ? sum + 8'h01 : sum;
      for (int k = 0; k < 8; k++) begin
         w.rx_byte = frame[k];
         if (k == 7) begin
            w.target_address = row.taddr;
            w.target_output = row.tout;
            w.in_reg_zero = row.izero;
            send_byte(w, row.check, row.data);
         end else begin
            w.target_address = 8'($urandom_range(0, 255));
            w.target_output = 8'($urandom_range(0, 255));
            w.in_reg_zero = 1'($urandom_range(0, 1));
            send_byte(w, REPLY_PREDICTED, '0);
         end
      end
      frame_bytes_sent += 8;
   endtask

   task automatic wait_replies_drained();
      req_push <= 1'b0;
      @(negedge clock);
      while (reply_words_due.size() != 0) @(negedge clock);
   endtask

   function automatic frame_row_type frame_row(
      input logic [7:0] cmd, input logic [7:0] addr, input logic [7:0] hi,
      input logic [7:0] lo, input logic [7:0] taddr, input logic [7:0] tout,
      input logic izero, input logic bad_sum, input reply_check_type check,
      input logic [39:0] data);
      frame_row_type row;
      row.cmd = cmd;
      row.addr = addr;
      row.hi = hi;
      row.lo = lo;
      row.taddr = taddr;
      row.tout = tout;
      row.izero = izero;
      row.bad_sum = bad_sum;
      row.check = check;
      row.data = data;
      return row;
   endfunction

   // result side: random pop with stalls and unbroken stretches
   always @(negedge clock) begin
      if (pop_run == 0) begin
         pop_pick = $urandom_range(0, 99);
         if (pop_pick < 15) begin
            pop_level = 1'b1;
            pop_run = $urandom_range(20, 60);
         end else if (pop_pick < 55) begin
            pop_level = 1'b1;
            pop_run = $urandom_range(1, 4);
         end else if (pop_pick < 95) begin
            pop_level = 1'b0;
            pop_run = $urandom_range(1, 3);
         end else begin
            pop_level = 1'b0;
            pop_run = $urandom_range(15, 40);
         end
      end
      pop_run = pop_run - 1;
      rsp_pop <= pop_level;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (reply_words_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_word.tx_byte, 8'h00);
         end else begin
            reply_want = reply_words_due.pop_front();
            if (rsp_word.tx_byte !== reply_want.tx_byte)
               report_mismatch("tx_byte", rsp_word.tx_byte, reply_want.tx_byte);
            if (rsp_word.frame_last !== reply_want.frame_last)
               report_mismatch("frame_last", 8'(rsp_word.frame_last),
                               8'(reply_want.frame_last));
            if (rsp_word.clock_enable !== reply_want.clock_enable)
               report_mismatch("clock_enable", 8'(rsp_word.clock_enable),
                               8'(reply_want.clock_enable));
            if (rsp_word.reset_enable !== reply_want.reset_enable)
               report_mismatch("reset_enable", 8'(rsp_word.reset_enable),
                               8'(reply_want.reset_enable));
            if (rsp_word.switch_source !== reply_want.switch_source)
               report_mismatch("switch_source", 8'(rsp_word.switch_source),
                               8'(reply_want.switch_source));
            if (rsp_word.address_drive !== reply_want.address_drive)
               report_mismatch("address_drive", 8'(rsp_word.address_drive),
                               8'(reply_want.address_drive));
            if (rsp_word.in_bus_drive !== reply_want.in_bus_drive)
               report_mismatch("in_bus_drive", 8'(rsp_word.in_bus_drive),
                               8'(reply_want.in_bus_drive));
            if (rsp_word.address_out !== reply_want.address_out)
               report_mismatch("address_out", rsp_word.address_out, reply_want.address_out);
            if (rsp_word.in_value_out !== reply_want.in_value_out)
               report_mismatch("in_value_out", rsp_word.in_value_out,
                               reply_want.in_value_out);
            if (rsp_word.reset_request !== reply_want.reset_request)
               report_mismatch("reset_request", 8'(rsp_word.reset_request),
                               8'(reply_want.reset_request));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("host_command_link regression: fail");
         $finish;
      end
   end

   initial begin
      frame_row_type row;
      req_word_type w;
      int pick;
      int burst;

      link_pos = 0;
      link_sum = '0;
      foreach (link_frame[i]) link_frame[i] = '0;
      link_is_open = 1'b0;
      link_mode = '0;
      link_pins = '0;
      link_addr_out = '0;
      link_in_value = '0;
      foreach (link_store[i]) link_store[i] = '0;

      // cmd addr hi lo taddr tout izero bad_sum check data
      directed_rows[0]  = frame_row(CHAR_WRITE, 8'h00, 8'h12, 8'h34, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_ABSENT, 40'h0);
      directed_rows[1]  = frame_row(CHAR_OPEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b1, REPLY_ABSENT, 40'h0);
      directed_rows[2]  = frame_row(CHAR_OPEN, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[3]  = frame_row(CHAR_OPEN, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[4]  = frame_row(CHAR_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h00_00_00_00_00);
      directed_rows[5]  = frame_row(CHAR_WRITE, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h00_FF_FF_00_00);
      directed_rows[6]  = frame_row(CHAR_WRITE, 8'h7F, 8'h00, 8'h01, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h7F_00_01_00_00);
      directed_rows[7]  = frame_row(CHAR_WRITE, 8'hFF, 8'hAA, 8'h55, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'hFF_AA_55_00_00);
      directed_rows[8]  = frame_row(CHAR_READ, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'hFF_AA_55_00_00);
      directed_rows[9]  = frame_row(CHAR_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h00_FF_FF_00_00);
      directed_rows[10] = frame_row(CHAR_READ, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_PREDICTED, 40'h0);
      directed_rows[11] = frame_row(CHAR_CONTROL, 8'hFF, 8'hFF, 8'h1F, 8'hFF, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'hFF_00_1F_00_00);
      directed_rows[12] = frame_row(CHAR_CONTROL, 8'h00, 8'h00, 8'h1F, 8'h00, 8'hFF, 1'b1,
                                    1'b0, REPLY_TYPED, 40'h00_FF_1F_00_00);
      directed_rows[13] = frame_row(CHAR_CONTROL, 8'h5A, 8'hA5, 8'h10, 8'h12, 8'h34, 1'b1,
                                    1'b0, REPLY_PREDICTED, 40'h0);
      directed_rows[14] = frame_row(CHAR_CONTROL, 8'h80, 8'h01, 8'h1F, 8'h56, 8'h78, 1'b0,
                                    1'b0, REPLY_PREDICTED, 40'h0);
      directed_rows[15] = frame_row(CHAR_CONTROL, 8'h00, 8'h00, 8'h00, 8'h9A, 8'hBC, 1'b0,
                                    1'b0, REPLY_PREDICTED, 40'h0);
      directed_rows[16] = frame_row(CHAR_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_ABSENT, 40'h0);
      directed_rows[17] = frame_row(CHAR_SAVE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[18] = frame_row(CHAR_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[19] = frame_row(CHAR_ERASE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[20] = frame_row(CHAR_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[21] = frame_row(CHAR_WRITE, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_PREDICTED, 40'h0);
      directed_rows[22] = frame_row(CHAR_CLOSE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_TYPED, 40'h0);
      directed_rows[23] = frame_row(CHAR_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
                                    1'b0, REPLY_ABSENT, 40'h0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle bytes other than sync are dropped
      w = '0;
      send_byte(w, REPLY_PREDICTED, '0);
      w = {8'hFF, 8'hFF, 8'hFF, 1'b1};
      send_byte(w, REPLY_PREDICTED, '0);
      w = {8'h7F, 8'h00, 8'h00, 1'b0};
      send_byte(w, REPLY_PREDICTED, '0);

      foreach (directed_rows[i]) send_frame(directed_rows[i]);
      wait_replies_drained();

      frame_bytes_sent = 0;
      while (frame_bytes_sent < RANDOM_FRAME_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 88) begin
            burst = $urandom_range(0, 99);
            if (!link_is_open && burst < 60) begin
               row.cmd = CHAR_OPEN;
            end else if (burst < 6) begin
               row.cmd = CHAR_OPEN;
            end else if (burst < 30) begin
               row.cmd = CHAR_CONTROL;
            end else if (burst < 55) begin
               row.cmd = CHAR_WRITE;
            end else if (burst < 78) begin
               row.cmd = CHAR_READ;
            end else if (burst < 83) begin
               row.cmd = CHAR_SAVE;
            end else if (burst < 87) begin
               row.cmd = CHAR_ERASE;
            end else if (burst < 92) begin
               row.cmd = CHAR_RESET;
            end else if (burst < 95) begin
               row.cmd = CHAR_CLOSE;
            end else begin
               row.cmd = 8'($urandom_range(0, 255));
            end
            burst = $urandom_range(0, 99);
            if (burst < 70) begin
               row.addr = 8'($urandom_range(0, 7));
            end else if (burst < 85) begin
               row.addr = 8'($urandom_range(0, STORE_WORDS - 1));
            end else begin
               row.addr = 8'($urandom_range(0, 255));
            end
            row.hi = 8'($urandom_range(0, 255));
            burst = $urandom_range(0, 3);
            if (row.cmd != CHAR_CONTROL || burst == 0) begin
               row.lo = 8'($urandom_range(0, 255));
            end else if (burst == 1) begin
               row.lo = link_mode;
            end else begin
               row.lo = 8'($urandom_range(0, 31));
            end
            row.taddr = 8'($urandom_range(0, 255));
            row.tout = 8'($urandom_range(0, 255));
            row.izero = 1'($urandom_range(0, 1));
            row.bad_sum = (pick >= 80);
            row.check = REPLY_PREDICTED;
            row.data = '0;
            send_frame(row);
         end else if (pick < 96) begin
            // line noise, then zeros to bring the receiver back to idle
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst + 8; k++) begin
               w.rx_byte = (k >= burst) ? 8'h00 :
                           ($urandom_range(0, 3) == 0) ? SYNC_BYTE :
                           8'($urandom_range(0, 255));
               w.target_address = 8'($urandom_range(0, 255));
               w.target_output = 8'($urandom_range(0, 255));
               w.in_reg_zero = 1'($urandom_range(0, 1));
               send_byte(w, REPLY_PREDICTED, '0);
            end
         end else begin
            wait_replies_drained();
         end
      end

      req_push <= 1'b0;
      while (reply_words_due.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (error_count == 0) begin
         $display("host_command_link regression: pass");
      end else begin
         $display("host_command_link regression: fail");
      end
      $finish;
   end

endmodule
